// ===== rtl/spi_mode0_slave_responder_assert.svh =====
// assertion macros used by the core
`ifndef SPI_MODE0_SLAVE_RESPONDER_ASSERT_SVH
`define SPI_MODE0_SLAVE_RESPONDER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define SPIMSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked on every edge, reset included
`define SPIMSR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SPIMSR_ASSERT(label, prop, msg)
`define SPIMSR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/spimsr_pkg.sv =====
package spimsr_pkg;

    // largest message, terminator included
    localparam int unsigned MaxMessage = 128;
    localparam int unsigned StoreDepth = 128;
    localparam logic [7:0] ReplyLenReset = 8'd33;
    localparam logic [7:0] ReplyLenMax =
        8'((MaxMessage < StoreDepth) ? MaxMessage : StoreDepth);
    localparam logic [7:0] RxByteLimit = 8'(MaxMessage - 1);
    localparam logic [2:0] LastBit = 3'd7;

    // fixed reply text, bytes past the end read as zero
    localparam logic [7:0] ReplyText [0:31] = '{
        8'h68, 8'h69, 8'h20, 8'h6d, 8'h61, 8'h73, 8'h74, 8'h65,
        8'h72, 8'h2c, 8'h20, 8'h74, 8'h68, 8'h69, 8'h73, 8'h20,
        8'h69, 8'h73, 8'h20, 8'h73, 8'h6c, 8'h61, 8'h76, 8'h65,
        8'h20, 8'h62, 8'h79, 8'h20, 8'h77, 8'h61, 8'h66, 8'h69
    };

    // one sample of the pins
    typedef struct packed {
        logic data_in;
        logic serial_clock;
        logic chip_select_n;
    } pin_t;

    // one result word
    typedef struct packed {
        logic [7:0] frame_bytes;
        logic       frame_was_reply;
        logic       frame_end;
        logic [6:0] byte_index;
        logic [7:0] received_byte;
        logic       byte_valid;
        logic       data_out;
    } res_t;

    // reply store lookup
    function automatic logic [7:0] reply_byte(input logic [6:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < 7'd32) begin
            b = ReplyText[idx[4:0]];
        end
        return b;
    endfunction

endpackage

// ===== rtl/spimsr_ibuf.sv =====
module spimsr_ibuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  spimsr_pkg::pin_t    pins_in,
    input  logic                advance,
    output logic                smp_valid,
    output spimsr_pkg::pin_t    smp_pins
);

    logic             valid_reg, valid_next;
    spimsr_pkg::pin_t pins_reg;

    // free when empty or when the held word moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // sample register
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pins_reg <= pins_in;
        end
    end

    assign smp_valid = valid_reg;
    assign smp_pins  = pins_reg;

endmodule

// ===== rtl/spimsr_core.sv =====
module spimsr_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                advance,
    input  spimsr_pkg::pin_t    pins,
    output spimsr_pkg::res_t    res
);

    logic [7:0] reply_length_reg;
    logic       last_clock_reg, last_clock_next;
    logic       last_select_reg, last_select_next;
    logic       reply_phase_reg, reply_phase_next;
    logic [7:0] shift_bits_reg, shift_bits_next;
    logic [2:0] bit_pos_reg, bit_pos_next;
    logic [7:0] byte_cnt_reg, byte_cnt_next;
    logic       finished_reg, finished_next;
    logic       half_bit_reg, half_bit_next;

    logic       prev_clk, rise, fall;
    logic [7:0] eff_len;
    logic [7:0] tx_byte;

    // saturate the configured reply length
    assign eff_len = (reply_length_reg > spimsr_pkg::ReplyLenMax) ?
                     spimsr_pkg::ReplyLenMax : reply_length_reg;

    // next state and result for the sample in the input register
    always_comb begin
        last_clock_next  = pins.serial_clock;
        last_select_next = pins.chip_select_n;
        reply_phase_next = reply_phase_reg;
        shift_bits_next  = shift_bits_reg;
        bit_pos_next     = bit_pos_reg;
        byte_cnt_next    = byte_cnt_reg;
        finished_next    = finished_reg;
        half_bit_next    = half_bit_reg;
        prev_clk         = last_clock_reg;
        rise             = 1'b0;
        fall             = 1'b0;
        tx_byte          = 8'h00;
        res              = '0;

        if (!pins.chip_select_n) begin
            // frame start clears the per-frame state
            if (last_select_reg) begin
                shift_bits_next = 8'h00;
                bit_pos_next    = 3'd0;
                byte_cnt_next   = 8'h00;
                finished_next   = 1'b0;
                half_bit_next   = 1'b0;
                prev_clk        = reply_phase_reg;
            end
            rise = pins.serial_clock && !prev_clk;
            fall = !pins.serial_clock && prev_clk;

            if (!reply_phase_reg) begin
                // receive: shift on rise, close the bit on fall
                if (!finished_next) begin
                    if (rise) begin
                        shift_bits_next = {shift_bits_next[6:0], pins.data_in};
                        half_bit_next   = 1'b1;
                    end else if (fall && half_bit_next) begin
                        half_bit_next = 1'b0;
                        if (bit_pos_next == spimsr_pkg::LastBit) begin
                            bit_pos_next = 3'd0;
                            if (byte_cnt_next < spimsr_pkg::RxByteLimit) begin
                                res.byte_valid    = 1'b1;
                                res.received_byte = shift_bits_next;
                                res.byte_index    = byte_cnt_next[6:0];
                                byte_cnt_next     = byte_cnt_next + 8'd1;
                            end
                            if (shift_bits_next == 8'h00) begin
                                finished_next = 1'b1;
                            end
                        end else begin
                            bit_pos_next = bit_pos_next + 3'd1;
                        end
                    end
                end
            end else begin
                // reply: advance on the fall after a rise
                if (byte_cnt_next >= eff_len) begin
                    finished_next = 1'b1;
                end
                if (!finished_next) begin
                    if (rise) begin
                        half_bit_next = 1'b1;
                    end else if (fall && half_bit_next) begin
                        half_bit_next = 1'b0;
                        if (bit_pos_next == spimsr_pkg::LastBit) begin
                            bit_pos_next  = 3'd0;
                            byte_cnt_next = byte_cnt_next + 8'd1;
                            if (byte_cnt_next >= eff_len) begin
                                finished_next = 1'b1;
                            end
                        end else begin
                            bit_pos_next = bit_pos_next + 3'd1;
                        end
                    end
                end
                // drive the current bit while low or through the high phase
                if (!finished_next && (!pins.serial_clock || half_bit_next)) begin
                    tx_byte      = spimsr_pkg::reply_byte(byte_cnt_next[6:0]);
                    res.data_out = tx_byte[~bit_pos_next];
                end
            end
        end else if (!last_select_reg) begin
            // deselect ends the frame and flips the phase
            res.frame_end       = 1'b1;
            res.frame_was_reply = reply_phase_reg;
            res.frame_bytes     = byte_cnt_reg;
            reply_phase_next    = !reply_phase_reg;
            half_bit_next       = 1'b0;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reply_length_reg <= spimsr_pkg::ReplyLenReset;
        end else if (cfg_we) begin
            reply_length_reg <= cfg_wdata;
        end
    end

    // frame state, updated as each sample moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_clock_reg  <= 1'b0;
            last_select_reg <= 1'b1;
            reply_phase_reg <= 1'b0;
            shift_bits_reg  <= 8'h00;
            bit_pos_reg     <= 3'd0;
            byte_cnt_reg    <= 8'h00;
            finished_reg    <= 1'b0;
            half_bit_reg    <= 1'b0;
        end else if (advance) begin
            last_clock_reg  <= last_clock_next;
            last_select_reg <= last_select_next;
            reply_phase_reg <= reply_phase_next;
            shift_bits_reg  <= shift_bits_next;
            bit_pos_reg     <= bit_pos_next;
            byte_cnt_reg    <= byte_cnt_next;
            finished_reg    <= finished_next;
            half_bit_reg    <= half_bit_next;
        end
    end

`include "spi_mode0_slave_responder_assert.svh"

    `SPIMSR_ASSERT(a_cnt_bound, byte_cnt_reg <= spimsr_pkg::ReplyLenMax, "byte count past store depth")
    `SPIMSR_ASSERT(a_rx_cnt_bound, (!reply_phase_reg && !last_select_reg) |-> (byte_cnt_reg <= spimsr_pkg::RxByteLimit), "receive count past limit")
    `SPIMSR_ASSERT(a_byte_not_end, advance |-> !(res.byte_valid && res.frame_end), "byte and frame end together")
    `SPIMSR_ASSERT(a_phase_flip, (advance && res.frame_end) |=> (reply_phase_reg != $past(reply_phase_reg)), "phase did not flip at frame end")

endmodule

// ===== rtl/spimsr_obuf.sv =====
module spimsr_obuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  spimsr_pkg::res_t    res_in,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output spimsr_pkg::res_t    res_out
);

    logic             valid_reg, valid_next;
    spimsr_pkg::res_t res_reg;

    // room when empty or when the held word leaves this cycle
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

endmodule

// ===== rtl/spi_mode0_slave_responder.sv =====
// SPI mode 0 slave that alternates a receive frame and a reply frame. Each input
// word is one sample of the chip-select, clock and data-in pins, and each
// sample yields exactly one output word. Edges are found against the previous
// sample, so each high and low phase of the master clock must be sampled at
// least once.
// Received bytes come out with their index (up to 127 per frame, a zero byte
// ends reception); the reply frame shifts out a fixed text, MSB first, for
// cfg_wdata bytes (saturated to 128). A word passes from the sample register
// through a single pass of frame logic into the result register, one word
// per cycle sustained while m_tready holds; a stalled output holds the word
// in the sample register. Write the length only while no word is in flight.
module spi_mode0_slave_responder (
    input  logic        aclk,
    input  logic        aresetn,
    // reply length register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // pin samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // chip_select_n, serial_clock, data_in, zero pad
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_out, received_byte, byte_index, frame_bytes
    output logic [1:0]  m_tuser,   // byte_valid, frame_was_reply
    output logic        m_tlast    // frame_end
);

    spimsr_pkg::pin_t pins_in, smp_pins;
    spimsr_pkg::res_t res_core, res_out;
    logic             smp_valid, obuf_free, advance;

    // unpack the sample word
    assign pins_in.chip_select_n = s_tdata[0];
    assign pins_in.serial_clock  = s_tdata[1];
    assign pins_in.data_in       = s_tdata[2];

    assign advance = smp_valid && obuf_free;

    spimsr_ibuf u_ibuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .pins_in   (pins_in),
        .advance   (advance),
        .smp_valid (smp_valid),
        .smp_pins  (smp_pins)
    );

    spimsr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .pins      (smp_pins),
        .res       (res_core)
    );

    spimsr_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .res_in   (res_core),
        .free     (obuf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_out)
    );

    // pack the result word
    assign m_tdata = {res_out.frame_bytes, res_out.byte_index,
                      res_out.received_byte, res_out.data_out};
    assign m_tuser = {res_out.frame_was_reply, res_out.byte_valid};
    assign m_tlast = res_out.frame_end;

endmodule
